// ===== rtl/core/sptd_pkg.sv =====
// Shared types and constants for the scratchpad temperature decoder.
`default_nettype none

package sptd_pkg;

   localparam int MAX_SENSORS_DEFAULT = 8;

   // Scratchpad byte positions
   localparam logic [3:0] POS_TEMP_LOW   = 4'd0;
   localparam logic [3:0] POS_TEMP_HIGH  = 4'd1;
   localparam logic [3:0] POS_CONFIG     = 4'd4;
   localparam logic [3:0] POS_REMAIN     = 4'd6;
   localparam logic [3:0] POS_PER_DEGREE = 4'd7;
   localparam logic [3:0] POS_CRC        = 4'd8;
   localparam logic [3:0] POS_DONE       = 4'd9;

   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam logic [7:0] CRC_INIT = 8'h00;

   localparam logic [7:0]  SHORT_FAMILY  = 8'h10;
   localparam logic [7:0]  PER_DEGREE_16 = 8'h10;
   localparam logic [15:0] REFINE_MASK   = 16'hFFF0;
   localparam logic [15:0] REFINE_BIAS   = 16'd12;
   localparam logic [7:0]  RES_FIELD     = 8'h60;
   localparam int          RES_SHIFT     = 5;

   // Resolution codes from the configuration byte
   localparam logic [1:0] RES_9BIT  = 2'd0;
   localparam logic [1:0] RES_10BIT = 2'd1;
   localparam logic [1:0] RES_11BIT = 2'd2;
   localparam logic [1:0] RES_12BIT = 2'd3;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic [7:0] family_code;
      logic [2:0] device_index;
   } req_type;

   typedef struct packed {
      logic               status;
      logic signed [15:0] temperature;
      logic [2:0]         sensor;
   } rsp_type;

   // Capture view handed from the byte tracker to the decoder
   typedef struct packed {
      logic       hit;
      logic       crc_ok;
      logic [7:0] temp_low;
      logic [7:0] temp_high;
      logic [1:0] res_bits;
      logic [7:0] remain_count;
      logic [7:0] count_per_degree;
   } cap_type;

endpackage

`default_nettype wire

// ===== rtl/core/sptd_capture.sv =====
// Byte tracker: byte count, running CRC-8 and captured scratchpad fields.
`default_nettype none

module sptd_capture (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire sptd_pkg::req_type item,
   output sptd_pkg::cap_type    cap
);

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = b;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ d[0];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ sptd_pkg::CRC_POLY;
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] temp_low_ff, temp_low_in;
   logic [7:0] temp_high_ff, temp_high_in;
   logic [1:0] res_bits_ff, res_bits_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] per_degree_ff, per_degree_in;

   logic [3:0] pos;
   logic [7:0] crc_base;
   logic [7:0] cfg_field;

   always_comb begin
      pos       = item.first ? sptd_pkg::POS_TEMP_LOW : byte_count_ff;
      crc_base  = item.first ? sptd_pkg::CRC_INIT : crc_ff;
      cfg_field = item.data_byte & sptd_pkg::RES_FIELD;

      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      temp_low_in   = temp_low_ff;
      temp_high_in  = temp_high_ff;
      res_bits_in   = res_bits_ff;
      remain_in     = remain_ff;
      per_degree_in = per_degree_ff;

      if (advance) begin
         if (pos < sptd_pkg::POS_CRC) begin
            crc_in        = crc8_update(crc_base, item.data_byte);
            byte_count_in = pos + 4'd1;
            unique case (pos)
               sptd_pkg::POS_TEMP_LOW:   temp_low_in   = item.data_byte;
               sptd_pkg::POS_TEMP_HIGH:  temp_high_in  = item.data_byte;
               sptd_pkg::POS_CONFIG:     res_bits_in   = cfg_field[sptd_pkg::RES_SHIFT +: 2];
               sptd_pkg::POS_REMAIN:     remain_in     = item.data_byte;
               sptd_pkg::POS_PER_DEGREE: per_degree_in = item.data_byte;
               default: ;
            endcase
         end else begin
            crc_in        = crc_base;
            byte_count_in = sptd_pkg::POS_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= sptd_pkg::POS_TEMP_LOW;
         crc_ff        <= sptd_pkg::CRC_INIT;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_low_ff   <= temp_low_in;
      temp_high_ff  <= temp_high_in;
      res_bits_ff   <= res_bits_in;
      remain_ff     <= remain_in;
      per_degree_ff <= per_degree_in;
   end

   assign cap.hit              = (pos == sptd_pkg::POS_CRC);
   assign cap.crc_ok           = (crc_base == item.data_byte);
   assign cap.temp_low         = temp_low_ff;
   assign cap.temp_high        = temp_high_ff;
   assign cap.res_bits         = res_bits_ff;
   assign cap.remain_count     = remain_ff;
   assign cap.count_per_degree = per_degree_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sptd_decode.sv =====
// Temperature decode: CRC check, short-format refinement, resolution mask.
`default_nettype none

module sptd_decode #(
   parameter int MaxSensors = sptd_pkg::MAX_SENSORS_DEFAULT
) (
   input  wire sptd_pkg::cap_type cap,
   input  wire logic [7:0]        family_code,
   input  wire logic [2:0]        device_index,
   output sptd_pkg::rsp_type      result
);

   logic [15:0] raw;
   logic [15:0] shifted;
   logic [15:0] refined;
   logic [15:0] masked;
   logic [15:0] value;

   always_comb begin
      raw     = {cap.temp_high, cap.temp_low};
      shifted = {raw[12:0], 3'b000};
      refined = (shifted & sptd_pkg::REFINE_MASK) + sptd_pkg::REFINE_BIAS
                - {8'h00, cap.remain_count};

      unique case (cap.res_bits)
         sptd_pkg::RES_9BIT:  masked = {raw[15:3], 3'b000};
         sptd_pkg::RES_10BIT: masked = {raw[15:2], 2'b00};
         sptd_pkg::RES_11BIT: masked = {raw[15:1], 1'b0};
         sptd_pkg::RES_12BIT: masked = raw;
         default:             masked = raw;
      endcase

      if (family_code == sptd_pkg::SHORT_FAMILY) begin
         value = (cap.count_per_degree == sptd_pkg::PER_DEGREE_16) ? refined : shifted;
      end else begin
         value = masked;
      end

      if (cap.crc_ok) begin
         result.status      = sptd_pkg::STATUS_OK;
         result.temperature = $signed(value);
      end else begin
         result.status      = sptd_pkg::STATUS_CRC_ERR;
         result.temperature = '0;
      end
      result.sensor = (int'(device_index) < MaxSensors) ? device_index : 3'd0;
   end

endmodule

`default_nettype wire

// ===== rtl/core/scratchpad_temperature_decode.sv =====
// Top level of the scratchpad temperature decoder.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   req     | in        | req_valid/req_stall | data_byte, first, family, idx
//   rsp     | out       | rsp_valid/rsp_stall | status, temperature, sensor
//
// One byte per cycle unless byte 8 meets a stalled result. A byte waits in
// the input register; CRC update, capture and decode run in the cycle it
// leaves it, and the result of byte 8 lands in the output register.
// Reset clears the byte count, the CRC and both valid flags.
// A stalled result only blocks a byte that itself produces a result; bytes
// 0 to 7 and trailing bytes keep flowing underneath it.
`default_nettype none

module scratchpad_temperature_decode #(
   parameter int MAX_SENSORS = sptd_pkg::MAX_SENSORS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sptd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sptd_pkg::rsp_type      rsp_data
);

   logic              s1_valid_ff, s1_valid_in;
   sptd_pkg::req_type s1_data_ff, s1_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sptd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sptd_pkg::cap_type cap;
   sptd_pkg::rsp_type result;

   logic req_take;
   logic rsp_take;
   logic s1_advance;

   // Track byte position and CRC for the byte held in the input register.
   sptd_capture u_capture (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_advance),
      .item    (s1_data_ff),
      .cap     (cap)
   );

   // Build the result for byte 8 from the captured fields.
   sptd_decode #(
      .MaxSensors (MAX_SENSORS)
   ) u_decode (
      .cap          (cap),
      .family_code  (s1_data_ff.family_code),
      .device_index (s1_data_ff.device_index),
      .result       (result)
   );

   // Advance the held byte unless it makes a result and the output slot is busy.
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign s1_advance = s1_valid_ff && (!cap.hit || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && cap.hit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payloads while their stage is stalled.
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) && !$past(reset) |-> $past(s1_valid_ff))
      else $error("result appeared without a byte in the input register");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == sptd_pkg::STATUS_CRC_ERR)
         |-> rsp_data_ff.temperature == 16'sd0)
      else $error("CRC error result carries a nonzero temperature");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(s1_advance && cap.hit))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
